### src/ttup_pkg.sv
// Package: widths, payload types and character helpers for the text to unsigned parser.
package ttup_pkg;

   localparam int WORD_BITS  = 32;
   localparam int COUNT_BITS = 16;
   localparam int BASE_BITS  = 6;
   localparam int CHAR_BITS  = 8;
   localparam int PROD_BITS  = WORD_BITS + BASE_BITS;
   localparam int STEP_BITS  = $clog2(BASE_BITS);
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [BASE_BITS-1:0] NO_DIGIT  = '1;
   localparam logic [BASE_BITS-1:0] BASE_MIN  = BASE_BITS'(2);
   localparam logic [BASE_BITS-1:0] BASE_MAX  = BASE_BITS'(36);
   localparam logic [BASE_BITS-1:0] BASE_OCT  = BASE_BITS'(8);
   localparam logic [BASE_BITS-1:0] BASE_DEC  = BASE_BITS'(10);
   localparam logic [BASE_BITS-1:0] BASE_HEX  = BASE_BITS'(16);
   localparam logic [BASE_BITS-1:0] BASE_AUTO = BASE_BITS'(0);

   localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_BITS-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_BITS-1:0] CHAR_CR    = 8'h0d;
   localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'h2b;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_UA    = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_UZ    = 8'h5a;
   localparam logic [CHAR_BITS-1:0] CHAR_LA    = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_LZ    = 8'h7a;
   localparam logic [CHAR_BITS-1:0] CHAR_LX    = 8'h78;
   localparam logic [CHAR_BITS-1:0] CASE_BIT   = 8'h20;
   localparam logic [CHAR_BITS-1:0] LETTER_OFS = 8'd55;

   localparam logic [CSR_ADDR_BITS-1:0] REG_NUMBER_BASE = '0;

   typedef struct packed {
      logic [CHAR_BITS-1:0] char_code;
      logic                 start_of_text;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]  parsed_value;
      logic [COUNT_BITS-1:0] chars_consumed;
      logic                  overflowed;
   } rsp_payload_type;

   // Digit value 0..35 of a character, NO_DIGIT for anything else.
   function automatic logic [BASE_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
      logic [CHAR_BITS-1:0] upper;
      upper = c & ~CASE_BIT;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         return BASE_BITS'(c[3:0]);
      end else if ((c >= CHAR_UA && c <= CHAR_UZ) || (c >= CHAR_LA && c <= CHAR_LZ)) begin
         return BASE_BITS'(upper - LETTER_OFS);
      end
      return NO_DIGIT;
   endfunction

   function automatic logic base_ok(input logic [BASE_BITS-1:0] b);
      return (b >= BASE_MIN) && (b <= BASE_MAX);
   endfunction

   // Saturating add of a small step to the position count.
   function automatic logic [COUNT_BITS-1:0] count_add(input logic [COUNT_BITS-1:0] cnt,
                                                        input logic [1:0] k);
      logic [COUNT_BITS:0] sum;
      sum = {1'b0, cnt} + (COUNT_BITS+1)'(k);
      return sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
   endfunction

endpackage

### src/text_to_unsigned_parser.sv
// Top level: streaming text to unsigned integer parser with a shared shift-add multiplier.
//
// Usage:
//   Input channel (req_*): one character per transaction; start_of_text marks the
//   first character of a new string. Leading white space and one sign are taken,
//   base 0 or 16 detects a 0x prefix, base 0 a leading-zero octal prefix.
//   Result channel (rsp_*): one transaction per parse, issued on the character that
//   ends it: value (negated for a minus sign, all ones on overflow), characters
//   consumed, overflow flag. Characters after a result are dropped until a start.
//   Configuration (APB): number_base at byte address 0, sampled at each start; it is to
//   be written only while idle, which the block itself does not enforce.
// Timing:
//   A digit that grows the accumulator passes through an accept cycle, an evaluate
//   cycle and the shared shift-add unit, one base bit per cycle, before the next
//   acceptance. Every other character passes through the accept and evaluate cycles only.
//   A result is loaded into the output register at the end of the evaluate cycle
//   and can be taken at the following edge.
// Reset: synchronous, active high; clears the parse state, the base register and
//   the output valid. The block accepts on the first cycle after reset.
// Stall: a result held under rsp_stall does not block acceptance; only a second
//   result waits in the evaluate cycle until the output register frees.
module text_to_unsigned_parser
   import ttup_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_payload_type          req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_payload_type          rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   // Sequencer codes
   localparam logic [1:0] SEQ_IDLE = 2'd0;
   localparam logic [1:0] SEQ_EVAL = 2'd1;
   localparam logic [1:0] SEQ_MUL  = 2'd2;

   // Parse phase codes
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_SPACE  = 3'd1;
   localparam logic [2:0] PH_SIGNED = 3'd2;
   localparam logic [2:0] PH_ZERO   = 3'd3;
   localparam logic [2:0] PH_XSEEN  = 3'd4;
   localparam logic [2:0] PH_DIGITS = 3'd5;
   localparam logic [2:0] PH_OVF    = 3'd6;

   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(BASE_BITS - 1);

   logic [1:0]            seq_ff, seq_in;
   logic [2:0]            phase_ff, phase_in;
   logic [BASE_BITS-1:0]  base_ff, base_in;
   logic [WORD_BITS-1:0]  acc_ff, acc_in;
   logic                  minus_ff, minus_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [BASE_BITS-1:0]  cfg_base_ff, cfg_base_in;
   req_payload_type       char_ff, char_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_ff, rsp_in;

   // Evaluate-cycle decode
   logic [CHAR_BITS-1:0]  ch;
   logic [BASE_BITS-1:0]  dig;
   logic [2:0]            ev_phase;
   logic [BASE_BITS-1:0]  ev_base;
   logic [WORD_BITS-1:0]  ev_acc;
   logic                  ev_minus;
   logic [COUNT_BITS-1:0] ev_cnt;
   logic                  ev_first;
   logic                  ev_digit;
   logic                  ev_emit;
   logic                  ev_mul;
   rsp_payload_type       ev_rsp;
   logic                  ev_blocked;

   // Shared shift-add unit
   logic [PROD_BITS-1:0]  mul_addend;
   logic [PROD_BITS-1:0]  mul_sum;

   logic                  req_take;
   logic                  cfg_write;

   assign req_stall = (seq_ff != SEQ_IDLE);
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Configuration port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr == REG_NUMBER_BASE) ? CSR_DATA_BITS'(cfg_base_ff) : '0;

   always_comb begin
      cfg_base_in = cfg_base_ff;
      if (cfg_write && paddr == REG_NUMBER_BASE) begin
         cfg_base_in = pwdata[BASE_BITS-1:0];
      end
   end

   // Character evaluation: one step of the parse state machine
   assign ch  = char_ff.char_code;
   assign dig = digit_of(ch);

   always_comb begin
      // a start restarts the parse with this character
      ev_phase = char_ff.start_of_text ? PH_SPACE : phase_ff;
      ev_base  = char_ff.start_of_text ? cfg_base_ff : base_ff;
      ev_acc   = char_ff.start_of_text ? '0 : acc_ff;
      ev_minus = char_ff.start_of_text ? 1'b0 : minus_ff;
      ev_cnt   = char_ff.start_of_text ? '0 : cnt_ff;
      ev_first = 1'b0;
      ev_digit = 1'b0;
      ev_emit  = 1'b0;
      ev_mul   = 1'b0;
      ev_rsp   = '0;

      case (ev_phase)
         PH_SPACE: begin
            if (ch == CHAR_SPACE || (ch >= CHAR_TAB && ch <= CHAR_CR)) begin
               ev_cnt = count_add(ev_cnt, 2'd1);
            end else if (ch == CHAR_PLUS || ch == CHAR_MINUS) begin
               ev_minus = (ch == CHAR_MINUS);
               ev_cnt   = count_add(ev_cnt, 2'd1);
               ev_phase = PH_SIGNED;
            end else begin
               ev_first = 1'b1;
            end
         end
         PH_SIGNED: begin
            ev_first = 1'b1;
         end
         PH_ZERO: begin
            if ((ch | CASE_BIT) == CHAR_LX) begin
               ev_base  = BASE_HEX;
               ev_phase = PH_XSEEN;
            end else begin
               if (ev_base == BASE_AUTO) begin
                  ev_base = BASE_OCT;
               end
               ev_phase = PH_DIGITS;
               ev_digit = 1'b1;
            end
         end
         PH_XSEEN: begin
            if (dig < BASE_HEX) begin
               ev_acc   = WORD_BITS'(dig);
               ev_cnt   = count_add(ev_cnt, 2'd2);
               ev_phase = PH_DIGITS;
            end else begin
               // prefix without digits: only the zero counts
               ev_emit  = 1'b1;
               ev_rsp   = '{parsed_value: '0, chars_consumed: ev_cnt, overflowed: 1'b0};
               ev_phase = PH_IDLE;
            end
         end
         PH_DIGITS, PH_OVF: begin
            ev_digit = 1'b1;
         end
         default: begin
            // idle: drop the character
         end
      endcase

      if (ev_first) begin
         if (ch == CHAR_ZERO && (ev_base == BASE_AUTO || ev_base == BASE_HEX)) begin
            ev_cnt   = count_add(ev_cnt, 2'd1);
            ev_acc   = '0;
            ev_phase = PH_ZERO;
         end else begin
            if (ev_base == BASE_AUTO) begin
               ev_base = BASE_DEC;
            end
            if (!base_ok(ev_base) || dig >= ev_base) begin
               // no digits at all
               ev_emit  = 1'b1;
               ev_rsp   = '0;
               ev_phase = PH_IDLE;
            end else begin
               ev_acc   = WORD_BITS'(dig);
               ev_cnt   = count_add(ev_cnt, 2'd1);
               ev_phase = PH_DIGITS;
            end
         end
      end

      if (ev_digit) begin
         if (!base_ok(ev_base) || dig >= ev_base) begin
            ev_emit = 1'b1;
            if (ev_phase == PH_OVF) begin
               ev_rsp = '{parsed_value: '1, chars_consumed: ev_cnt, overflowed: 1'b1};
            end else begin
               ev_rsp = '{parsed_value: ev_minus ? (~ev_acc + WORD_BITS'(1)) : ev_acc,
                          chars_consumed: ev_cnt, overflowed: 1'b0};
            end
            ev_phase = PH_IDLE;
         end else begin
            ev_cnt = count_add(ev_cnt, 2'd1);
            // past overflow the digits only count
            ev_mul = (ev_phase != PH_OVF);
         end
      end
   end

   // hold the result in evaluate while the output register is still occupied
   assign ev_blocked = ev_emit && rsp_valid_ff && rsp_stall;

   // One base bit per cycle: add the shifted accumulator when that bit is set
   assign mul_addend = base_ff[step_ff] ? (PROD_BITS'(acc_ff) << step_ff) : '0;
   assign mul_sum    = prod_ff + mul_addend;

   always_comb begin
      seq_in       = seq_ff;
      phase_in     = phase_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      minus_in     = minus_ff;
      cnt_in       = cnt_ff;
      char_in      = char_ff;
      prod_in      = prod_ff;
      step_in      = step_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (seq_ff)
         SEQ_IDLE: begin
            if (req_take) begin
               char_in = req_data;
               seq_in  = SEQ_EVAL;
            end
         end
         SEQ_EVAL: begin
            if (!ev_blocked) begin
               phase_in = ev_phase;
               base_in  = ev_base;
               acc_in   = ev_acc;
               minus_in = ev_minus;
               cnt_in   = ev_cnt;
               if (ev_emit) begin
                  rsp_in       = ev_rsp;
                  rsp_valid_in = 1'b1;
               end
               if (ev_mul) begin
                  // seed the product with the new digit
                  prod_in = PROD_BITS'(dig);
                  step_in = '0;
                  seq_in  = SEQ_MUL;
               end else begin
                  seq_in = SEQ_IDLE;
               end
            end
         end
         SEQ_MUL: begin
            prod_in = mul_sum;
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == LAST_STEP) begin
               if (mul_sum[PROD_BITS-1:WORD_BITS] != '0) begin
                  phase_in = PH_OVF;
               end else begin
                  acc_in = mul_sum[WORD_BITS-1:0];
               end
               seq_in = SEQ_IDLE;
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         phase_ff     <= PH_IDLE;
         base_ff      <= '0;
         acc_ff       <= '0;
         minus_ff     <= 1'b0;
         cnt_ff       <= '0;
         cfg_base_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         phase_ff     <= phase_in;
         base_ff      <= base_in;
         acc_ff       <= acc_in;
         minus_ff     <= minus_in;
         cnt_ff       <= cnt_in;
         cfg_base_ff  <= cfg_base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      char_ff <= char_in;
      prod_ff <= prod_in;
      step_ff <= step_in;
      rsp_ff  <= rsp_in;
   end

endmodule

### src/ttup_checker.sv
// Checker: port-level assertions for the text to unsigned parser, bound to the top level.
module ttup_checker
   import ttup_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // every character passes through the evaluate state before the next is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted on consecutive cycles");

   // saturation goes with the overflow flag
   a_ovf_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflowed |-> rsp_data.parsed_value == '1)
      else $error("overflow without saturated value");

   // nothing consumed means nothing parsed
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.chars_consumed == '0
      |-> rsp_data.parsed_value == '0 && !rsp_data.overflowed)
      else $error("value reported with no characters consumed");

endmodule

bind text_to_unsigned_parser ttup_checker u_ttup_checker (.*);

### sim/tb_text_to_unsigned_parser.sv
// Testbench for the streaming text to unsigned integer parser.
`timescale 1ns / 100ps

module tb_text_to_unsigned_parser;
   import ttup_pkg::*;

   // Receiver hold-off length for the backpressure test, in clock cycles.
   localparam int HOLD_CYCLES = 300;
   // Longest wait for outstanding results before a configuration write or the end.
   localparam int DRAIN_LIMIT = 20000;
   // Quiet cycles after the last result: covers a digit still in the shift-add unit.
   localparam int SETTLE_CYCLES = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
   localparam logic [WORD_BITS-1:0]  WORD_TOP  = '1;

   // Parse progress of the scoreboard copy of the block.
   typedef enum logic [2:0] {
      WAIT_START, LEAD_SPACE, AFTER_SIGN, LEAD_ZERO, PREFIX_X, IN_DIGITS, SATURATED
   } scan_state_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_payload_type          req_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_payload_type          rsp_data;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   // Scoreboard copy of the parser state and its base register.
   scan_state_type           scan_st;
   logic [BASE_BITS-1:0]     base_reg;
   logic [BASE_BITS-1:0]     cur_base;
   logic [WORD_BITS-1:0]     acc;
   logic                     neg;
   logic [COUNT_BITS-1:0]    pos_count;

   rsp_payload_type          pending_parses[$];
   int                       error_count;
   int                       live_chars;
   bit                       calm;
   int                       hold_ticket;
   int                       hold_taken;
   int                       hold_left;
   int                       rsp_wait;
   logic                     next_stall;
   rsp_payload_type          want;

   text_to_unsigned_parser DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   //---------------------------------------------------------------------------
   // Scoreboard: character classes and parse steps
   //---------------------------------------------------------------------------

   // Digit value 0..35, or NO_DIGIT for anything that is not a digit or letter.
   function automatic logic [BASE_BITS-1:0] char_digit(input logic [CHAR_BITS-1:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return BASE_BITS'(c - CHAR_ZERO);
      if (c >= CHAR_LA && c <= CHAR_LZ) return BASE_BITS'(c - CHAR_LA + 10);
      if (c >= CHAR_UA && c <= CHAR_UZ) return BASE_BITS'(c - CHAR_UA + 10);
      return NO_DIGIT;
   endfunction

   function automatic bit radix_ok(input logic [BASE_BITS-1:0] b);
      return b >= BASE_MIN && b <= BASE_MAX;
   endfunction

   function automatic bit is_space(input logic [CHAR_BITS-1:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   // Advance the consumed count, pinned at its top value.
   function automatic void bump_count(input int k);
      if (int'(pos_count) > int'(COUNT_TOP) - k) pos_count = COUNT_TOP;
      else pos_count = pos_count + COUNT_BITS'(k);
   endfunction

   // Queue the one result of a parse and go back to waiting for a start.
   function automatic void close_parse(input logic [WORD_BITS-1:0] v,
                                       input logic [COUNT_BITS-1:0] n,
                                       input logic ovf);
      rsp_payload_type r;
      r.parsed_value   = v;
      r.chars_consumed = n;
      r.overflowed     = ovf;
      pending_parses.push_back(r);
      scan_st = WAIT_START;
   endfunction

   // One character in the digit run: accumulate, or end the parse.
   function automatic void take_digit(input logic [CHAR_BITS-1:0] c);
      logic [BASE_BITS-1:0] d;
      logic [63:0]          prod;
      d = char_digit(c);
      if (!radix_ok(cur_base) || d >= cur_base) begin
         if (scan_st == SATURATED) close_parse(WORD_TOP, pos_count, 1'b1);
         else close_parse(neg ? WORD_BITS'(0) - acc : acc, pos_count, 1'b0);
         return;
      end
      bump_count(1);
      // Once saturated, digits only advance the count.
      if (scan_st == SATURATED) return;
      prod = 64'(acc) * 64'(cur_base) + 64'(d);
      if (prod[63:WORD_BITS] != '0) scan_st = SATURATED;
      else acc = prod[WORD_BITS-1:0];
   endfunction

   // First character after white space and sign: prefix zero, first digit or nothing.
   function automatic void take_first(input logic [CHAR_BITS-1:0] c);
      logic [BASE_BITS-1:0] d;
      if (c == CHAR_ZERO && (cur_base == BASE_AUTO || cur_base == BASE_HEX)) begin
         bump_count(1);
         acc     = '0;
         scan_st = LEAD_ZERO;
         return;
      end
      if (cur_base == BASE_AUTO) cur_base = BASE_DEC;
      d = char_digit(c);
      // No digit at all: the end position is the start, so the count is zero.
      if (!radix_ok(cur_base) || d >= cur_base) begin
         close_parse('0, '0, 1'b0);
         return;
      end
      acc = WORD_BITS'(d);
      bump_count(1);
      scan_st = IN_DIGITS;
   endfunction

   // Update the scoreboard with one accepted character and queue any result.
   function automatic void track_char(input logic [CHAR_BITS-1:0] c, input logic sot);
      logic [BASE_BITS-1:0] d;
      if (sot) begin
         // A start abandons any open parse; the base is sampled here.
         scan_st   = LEAD_SPACE;
         cur_base  = base_reg;
         acc       = '0;
         neg       = 1'b0;
         pos_count = '0;
      end
      if (scan_st != WAIT_START) live_chars++;
      case (scan_st)
         LEAD_SPACE: begin
            if (is_space(c)) begin
               bump_count(1);
            end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               neg = (c == CHAR_MINUS);
               bump_count(1);
               scan_st = AFTER_SIGN;
            end else begin
               take_first(c);
            end
         end
         AFTER_SIGN: take_first(c);
         LEAD_ZERO: begin
            if ((c | CASE_BIT) == CHAR_LX) begin
               cur_base = BASE_HEX;
               scan_st  = PREFIX_X;
            end else begin
               // A lone leading zero under auto detection means octal.
               if (cur_base == BASE_AUTO) cur_base = BASE_OCT;
               scan_st = IN_DIGITS;
               take_digit(c);
            end
         end
         PREFIX_X: begin
            d = char_digit(c);
            if (d < BASE_HEX) begin
               acc = WORD_BITS'(d);
               bump_count(2);
               scan_st = IN_DIGITS;
            end else begin
               // "0x" with no hex digit: only the zero counts.
               close_parse('0, pos_count, 1'b0);
            end
         end
         IN_DIGITS, SATURATED: take_digit(c);
         default: ;
      endcase
   endfunction

   //---------------------------------------------------------------------------
   // Drivers
   //---------------------------------------------------------------------------

   // Idle cycles before a transaction or after a result; none while calm.
   function automatic int draw_wait();
      if (calm || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 14);
   endfunction

   // Offer one character and hold it until the block takes it. Valid stays high on
   // return so that a back-to-back character does not drop it in the same step.
   task automatic send_char(input logic [CHAR_BITS-1:0] c, input logic sot);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= '{char_code: c, start_of_text: sot};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      track_char(c, sot);
   endtask

   task automatic send_text(input string s, input bit fresh);
      for (int i = 0; i < s.len(); i++) send_char(s[i], fresh && i == 0);
   endtask

   // Drop valid, wait for every queued result, then let the block settle.
   task automatic wait_quiet();
      int limit;
      req_valid <= 1'b0;
      limit = DRAIN_LIMIT;
      while (pending_parses.size() != 0 && limit > 0) begin
         @(posedge clock);
         limit--;
      end
      if (pending_parses.size() != 0) begin
         $error("%0d results never arrived", pending_parses.size());
         error_count++;
         pending_parses.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready.
   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_base(input logic [BASE_BITS-1:0] b);
      wait_quiet();
      csr_write(REG_NUMBER_BASE, CSR_DATA_BITS'(b));
      base_reg = b;
   endtask

   // Character for digit value v, letters in either case.
   function automatic logic [CHAR_BITS-1:0] digit_char(input int v);
      if (v < 10) return CHAR_ZERO + CHAR_BITS'(v);
      return ($urandom_range(0, 1) ? CHAR_LA : CHAR_UA) + CHAR_BITS'(v - 10);
   endfunction

   // One well-formed string with random content: white space, sign, prefix,
   // digits below the effective base, a terminator and some ignored tail.
   task automatic send_random_text();
      int                   eff;
      int                   n;
      int                   pick;
      bit                   first;
      logic [CHAR_BITS-1:0] c;
      first = 1'b1;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) begin
         pick = $urandom_range(0, 5);
         c = (pick == 5) ? CHAR_SPACE : CHAR_TAB + CHAR_BITS'(pick);
         send_char(c, first);
         first = 1'b0;
      end
      pick = $urandom_range(0, 3);
      if (pick < 2) begin
         send_char(pick == 0 ? CHAR_PLUS : CHAR_MINUS, first);
         first = 1'b0;
      end
      eff = radix_ok(base_reg) ? int'(base_reg) : 10;
      if (base_reg == BASE_AUTO || base_reg == BASE_HEX) begin
         pick = $urandom_range(0, 2);
         if (pick == 0) begin
            send_char(CHAR_ZERO, first);
            send_char($urandom_range(0, 1) ? CHAR_LX : (CHAR_LX & ~CASE_BIT), 1'b0);
            first = 1'b0;
            eff   = 16;
         end else if (pick == 1) begin
            send_char(CHAR_ZERO, first);
            first = 1'b0;
            eff   = (base_reg == BASE_AUTO) ? 8 : 16;
         end
      end
      // Mostly short numbers; long runs drive the accumulator into overflow.
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 7);
      repeat (n) begin
         send_char(digit_char($urandom_range(0, eff - 1)), first);
         first = 1'b0;
      end
      // Usually a sure terminator; sometimes any byte, which may extend the number.
      if ($urandom_range(0, 4) == 0) begin
         c = CHAR_BITS'($urandom_range(0, 255));
      end else begin
         do c = CHAR_BITS'($urandom_range(0, 255)); while (char_digit(c) < eff);
      end
      send_char(c, first);
      repeat ($urandom_range(0, 2)) send_char(CHAR_BITS'($urandom_range(0, 255)), 1'b0);
   endtask

   //---------------------------------------------------------------------------
   // Result checker and receiver stall
   //---------------------------------------------------------------------------

   initial begin
      rsp_stall   = 1'b0;
      hold_taken  = 0;
      hold_left   = 0;
      rsp_wait    = 0;
      error_count = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (pending_parses.size() == 0) begin
               $error("result with none pending: value %h count %0d ovf %b",
                      rsp_data.parsed_value, rsp_data.chars_consumed, rsp_data.overflowed);
               error_count++;
            end else begin
               want = pending_parses.pop_front();
               if (rsp_data.parsed_value !== want.parsed_value) begin
                  $error("parsed_value: expected %h, got %h",
                         want.parsed_value, rsp_data.parsed_value);
                  error_count++;
               end
               if (rsp_data.chars_consumed !== want.chars_consumed) begin
                  $error("chars_consumed: expected %0d, got %0d",
                         want.chars_consumed, rsp_data.chars_consumed);
                  error_count++;
               end
               if (rsp_data.overflowed !== want.overflowed) begin
                  $error("overflowed: expected %b, got %b",
                         want.overflowed, rsp_data.overflowed);
                  error_count++;
               end
            end
            rsp_wait = draw_wait();
         end
         // A new ticket starts a long hold-off, counted down here.
         if (hold_ticket != hold_taken) begin
            hold_taken = hold_ticket;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            next_stall = 1'b1;
         end else begin
            next_stall = 1'b0;
         end
         rsp_stall <= next_stall;
      end
   end

   //---------------------------------------------------------------------------
   // Tests
   //---------------------------------------------------------------------------

   // Reset base (auto): white space, sign, hex and octal prefixes, bare "0x",
   // a top-bit terminator, a NUL string with no digits, and a restart that drops a parse.
   task automatic test_auto_base();
      send_text(" \t-0x1fg", 1'b1);
      send_text("017", 1'b1);
      send_char(8'h80, 1'b0);
      send_text("0x.", 1'b1);
      send_char(8'h00, 1'b1);
      send_text("+9", 1'b1);
      send_text("?", 1'b1);
   endtask

   // Largest value, signed overflow, and an invalid base.
   task automatic test_base_extremes();
      set_base(BASE_HEX);
      send_text("ffffffff ", 1'b1);
      set_base(BASE_MAX);
      send_text("-zzzzzzz!", 1'b1);
      set_base(BASE_BITS'(63));
      send_text("5", 1'b1);
   endtask

   // Hold the result side off for a long stretch while short numbers keep coming,
   // so the block fills and stalls its input; then pause until all results land.
   task automatic test_backpressure();
      set_base(BASE_DEC);
      hold_ticket++;
      calm = 1'b1;
      repeat (30) send_text("7 ", 1'b1);
      calm = 1'b0;
      wait_quiet();
   endtask

   // Random strings under a sweep of bases, with occasional raw noise.
   task automatic test_random_text();
      logic [BASE_BITS-1:0] bases[11];
      int                   target;
      bases = '{BASE_AUTO, BASE_DEC, BASE_HEX, BASE_MIN, BASE_MAX, BASE_OCT, BASE_AUTO,
                BASE_BITS'(1), BASE_BITS'(37), BASE_BITS'(63),
                BASE_BITS'($urandom_range(3, 35))};
      foreach (bases[i]) begin
         set_base(bases[i]);
         // Two phases run without any idling on either side.
         calm   = (i == 1 || i == 6);
         target = live_chars + (radix_ok(bases[i]) || bases[i] == BASE_AUTO ? 200 : 60);
         while (live_chars < target) begin
            if ($urandom_range(0, 9) == 0) begin
               send_char(CHAR_BITS'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
               send_random_text();
            end
         end
         calm = 1'b0;
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      calm        = 1'b0;
      hold_ticket = 0;
      live_chars  = 0;
      base_reg    = BASE_AUTO;
      scan_st     = WAIT_START;
      cur_base    = '0;
      acc         = '0;
      neg         = 1'b0;
      pos_count   = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_auto_base();
      test_base_extremes();
      test_backpressure();
      test_random_text();

      wait_quiet();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### text_to_unsigned_parser.f
src/ttup_pkg.sv
src/text_to_unsigned_parser.sv
src/ttup_checker.sv
sim/tb_text_to_unsigned_parser.sv
